// ----- hdl/sfd_pkg.sv -----
package sfd_pkg;

    // Framing bytes
    localparam logic [7:0] AT_SIGN = 8'h40;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    // Length limits: a frame holds length+6 bytes, and the cap keeps that
    // inside the 12-bit position counter.
    localparam logic [15:0] MIN_LENGTH    = 16'd6;
    localparam logic [11:0] LENGTH_CAP    = 12'd4089;
    localparam logic [11:0] MAX_LEN_RESET = 12'd1000;

    // Positions of the header fields within the frame, '@' counting as one
    localparam logic [11:0] POS_LEN_LO     = 12'd6;
    localparam logic [11:0] POS_LEN_HI     = 12'd7;
    localparam logic [11:0] POS_SOURCE     = 12'd8;
    localparam logic [11:0] POS_DEST       = 12'd9;
    localparam logic [11:0] POS_NODE_COUNT = 12'd10;
    localparam logic [11:0] POS_LAST_HDR   = 12'd11;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic REG_MAX_FRAME_LENGTH = 1'b0;

    localparam int unsigned M_TDATA_W = 72;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_DISCARD   = 3'd0,
        ST_HEADER    = 3'd1,
        ST_BODY      = 3'd2,
        ST_COMPLETE  = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_NO_LF     = 3'd5,
        ST_TOO_SHORT = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        status_t     byte_status;
        logic [11:0] frame_position;
        logic [15:0] length_field;
        logic [7:0]  source_node;
        logic [7:0]  dest_node;
        logic [7:0]  node_byte_count;
        logic [7:0]  message_id;
    } sfd_result_t;

endpackage

// ----- hdl/sfd_cfg.sv -----
module sfd_cfg
    import sfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [11:0]           max_frame_length
);

    logic [11:0] max_len_reg;
    logic [11:0] max_len_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // The register index is the word address; writes to other words are dropped.
    always_comb begin
        max_len_next = max_len_reg;
        if (wr_en && (paddr[2] == REG_MAX_FRAME_LENGTH)) begin
            max_len_next = pwdata[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_FRAME_LENGTH) begin
            prdata = {{(APB_DATA_W-12){1'b0}}, max_len_reg};
        end
    end

    assign max_frame_length = max_len_reg;

endmodule

// ----- hdl/sfd_parser.sv -----
module sfd_parser
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [11:0] max_frame_length,
    output sfd_result_t result
);

    phase_t      phase_reg,  phase_next;
    logic [11:0] count_reg,  count_next;
    logic [15:0] len_reg,    len_next;
    logic [7:0]  src_reg,    src_next;
    logic [7:0]  dst_reg,    dst_next;
    logic [7:0]  ncnt_reg,   ncnt_next;
    logic [7:0]  id_reg,     id_next;

    logic [11:0] count_inc;
    logic [11:0] limit;
    logic [15:0] len_full;
    logic [15:0] end_pos;

    assign count_inc = count_reg + 12'd1;
    assign limit     = (max_frame_length > LENGTH_CAP) ? LENGTH_CAP : max_frame_length;
    assign len_full  = {rx_byte, len_reg[7:0]};
    assign end_pos   = len_reg + MIN_LENGTH;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        ncnt_next  = ncnt_reg;
        id_next    = id_reg;

        result                 = '0;
        result.byte_out        = rx_byte;
        result.byte_status     = ST_DISCARD;

        unique case (phase_reg)
            PH_HEADER: begin
                count_next            = count_inc;
                result.frame_position = count_inc;
                result.byte_status    = ST_HEADER;
                if (count_inc == POS_LEN_LO) begin
                    len_next = {8'd0, rx_byte};
                end else if (count_inc == POS_LEN_HI) begin
                    len_next = len_full;
                    if (len_full > {4'd0, limit}) begin
                        result.byte_status  = ST_TOO_LONG;
                        result.length_field = len_full;
                    end else if (len_full < MIN_LENGTH) begin
                        result.byte_status  = ST_TOO_SHORT;
                        result.length_field = len_full;
                    end
                    if ((len_full > {4'd0, limit}) || (len_full < MIN_LENGTH)) begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                        len_next   = '0;
                        src_next   = '0;
                        dst_next   = '0;
                        ncnt_next  = '0;
                        id_next    = '0;
                    end
                end else if (count_inc == POS_SOURCE) begin
                    src_next = rx_byte;
                end else if (count_inc == POS_DEST) begin
                    dst_next = rx_byte;
                end else if (count_inc == POS_NODE_COUNT) begin
                    ncnt_next = rx_byte;
                end else if (count_inc >= POS_LAST_HDR) begin
                    id_next    = rx_byte;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                count_next            = count_inc;
                result.frame_position = count_inc;
                result.byte_status    = ST_BODY;
                if ({4'd0, count_inc} == end_pos) begin
                    if (rx_byte == LF_BYTE) begin
                        result.byte_status     = ST_COMPLETE;
                        result.length_field    = len_reg;
                        result.source_node     = src_reg;
                        result.dest_node       = dst_reg;
                        result.node_byte_count = ncnt_reg;
                        result.message_id      = id_reg;
                    end else begin
                        result.byte_status = ST_NO_LF;
                    end
                    phase_next = PH_IDLE;
                    count_next = '0;
                    len_next   = '0;
                    src_next   = '0;
                    dst_next   = '0;
                    ncnt_next  = '0;
                    id_next    = '0;
                end
            end
            default: begin
                if (rx_byte == AT_SIGN) begin
                    phase_next            = PH_HEADER;
                    count_next            = 12'd1;
                    len_next              = '0;
                    src_next              = '0;
                    dst_next              = '0;
                    ncnt_next             = '0;
                    id_next               = '0;
                    result.frame_position = 12'd1;
                    result.byte_status    = ST_HEADER;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            ncnt_reg  <= '0;
            id_reg    <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            ncnt_reg  <= ncnt_next;
            id_reg    <= id_next;
        end
    end

    // A frame in its body always carries a length that passed the checks.
    a_body_len_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> ((len_reg >= MIN_LENGTH) && (len_reg <= {4'd0, LENGTH_CAP})))
        else $error("body phase with an unchecked length");

    // The body must end before the position counter passes the frame end.
    a_body_before_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> ({4'd0, count_reg} < end_pos))
        else $error("position counter ran past the frame end");

    // Idle means everything captured for a frame has been cleared.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> ((count_reg == '0) && (len_reg == '0) && (id_reg == '0)))
        else $error("frame state left over while idle");

endmodule

// ----- hdl/sfd_out_stage.sv -----
module sfd_out_stage
    import sfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  sfd_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output sfd_result_t out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    sfd_result_t main_reg,       main_next;
    sfd_result_t skid_reg,       skid_next;
    logic        in_fire;
    logic        out_fire;

    // Ready depends only on a register, so the stall does not ripple upstream.
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_fire) begin
            main_valid_next = skid_valid_reg || in_fire;
            main_next       = skid_valid_reg ? skid_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // The skid entry is younger than the output entry, so it never stands alone.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without an output entry");

endmodule

// ----- hdl/sonar_frame_deframer_unit.sv -----
// Sonar frame deframer.
//
// The slave stream takes one received serial byte per transfer in s_tdata.
// Idle bytes are discarded until '@' opens a frame; the parser then tracks
// the header, checks the little-endian length against max_frame_length and
// follows the body until the frame holds length+6 bytes, the last of which
// must be LF. Every input byte produces exactly one transfer on the master
// stream carrying the byte, its status (in m_tuser), its frame position and,
// when a frame completes, the captured header fields.
//
// Throughput is one byte per cycle while m_tready keeps up: the parser
// updates its frame state and the output stage registers the result in
// the same cycle. A two-entry output stage (output register plus skid
// register) lets the block accept a byte while a result waits;
// s_tready falls only once both entries are full under a stalled m_tready.
//
// Reset (aresetn low, synchronous) returns the parser to waiting for '@',
// empties the output stage and sets max_frame_length to 1000. The user writes
// the limit (APB address 0) only with no frame in flight; not enforced.
module sonar_frame_deframer_unit
    import sfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] byte_out, [19:8] frame_position, [35:20] length_field,
    // [43:36] source_node, [51:44] dest_node, [59:52] node_byte_count,
    // [67:60] message_id, [71:68] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [2:0]            m_tuser,   // [2:0] byte_status
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [11:0] max_frame_length;
    logic        s_fire;
    sfd_result_t parse_result;
    sfd_result_t out_result;

    // The parser state advances only on an accepted input transfer.
    assign s_fire = s_tvalid && s_tready;

    sfd_cfg u_cfg (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .max_frame_length (max_frame_length)
    );

    sfd_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (s_fire),
        .rx_byte          (s_tdata),
        .max_frame_length (max_frame_length),
        .result           (parse_result)
    );

    sfd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parse_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result fields, lowest first, padded with zeros to whole bytes.
    assign m_tdata = {4'd0,
                      out_result.message_id,
                      out_result.node_byte_count,
                      out_result.dest_node,
                      out_result.source_node,
                      out_result.length_field,
                      out_result.frame_position,
                      out_result.byte_out};
    assign m_tuser = out_result.byte_status;

endmodule

// ----- sim/sonar_frame_deframer_unit_test.sv -----
module sonar_frame_deframer_unit_test;
    import sfd_pkg::*;

    // How long the receiver holds m_tready low, once during the run: long
    // enough for the two-entry output stage to fill and stall s_tready.
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'(4 * REG_MAX_FRAME_LENGTH);

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [7:0] byte_out, [19:8] frame_position, [35:20] length_field,
    // [43:36] source_node, [51:44] dest_node, [59:52] node_byte_count,
    // [67:60] message_id, [71:68] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [2:0]            m_tuser;         // [2:0] byte_status
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sonar_frame_deframer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Our own copy of the parser state, updated once per accepted input
    // transfer. It starts at the reset values, as reset is applied only once.
    phase_t      frame_phase     = PH_IDLE;
    logic [11:0] frame_count     = '0;
    logic [15:0] held_length     = '0;
    logic [7:0]  held_source     = '0;
    logic [7:0]  held_dest       = '0;
    logic [7:0]  held_node_count = '0;
    logic [7:0]  held_msg_id     = '0;
    logic [11:0] length_limit    = MAX_LEN_RESET;

    // Parsed results still owed by the block, oldest first.
    sfd_result_t parsed_due[$];

    int failures          = 0;
    int bytes_sent        = 0;
    bit idling_on         = 1'b1;
    int long_holds_asked  = 0;
    int long_holds_served = 0;

    // Both the end of a frame and the opening '@' wipe every captured field.
    function automatic void clear_capture();
        frame_phase     = PH_IDLE;
        frame_count     = '0;
        held_length     = '0;
        held_source     = '0;
        held_dest       = '0;
        held_node_count = '0;
        held_msg_id     = '0;
    endfunction

    // Works out the single result that one received byte produces and queues it.
    function automatic void predict_parse(input logic [7:0] rx);
        sfd_result_t r;
        logic [11:0] eff_limit;
        r             = '0;
        r.byte_out    = rx;
        r.byte_status = ST_DISCARD;
        case (frame_phase)
            PH_HEADER: begin
                frame_count      = frame_count + 12'd1;
                r.frame_position = frame_count;
                r.byte_status    = ST_HEADER;
                if (frame_count == POS_LEN_LO) begin
                    held_length = {8'h00, rx};
                end else if (frame_count == POS_LEN_HI) begin
                    // Limits above the cap behave as the cap, so that length+6
                    // always fits the 12-bit position.
                    eff_limit   = (length_limit > LENGTH_CAP) ? LENGTH_CAP : length_limit;
                    held_length = {rx, held_length[7:0]};
                    if (held_length > {4'h0, eff_limit}) begin
                        r.byte_status  = ST_TOO_LONG;
                        r.length_field = held_length;
                        clear_capture();
                    end else if (held_length < MIN_LENGTH) begin
                        r.byte_status  = ST_TOO_SHORT;
                        r.length_field = held_length;
                        clear_capture();
                    end
                end else if (frame_count == POS_SOURCE) begin
                    held_source = rx;
                end else if (frame_count == POS_DEST) begin
                    held_dest = rx;
                end else if (frame_count == POS_NODE_COUNT) begin
                    held_node_count = rx;
                end else if (frame_count >= POS_LAST_HDR) begin
                    held_msg_id = rx;
                    frame_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                frame_count      = frame_count + 12'd1;
                r.frame_position = frame_count;
                r.byte_status    = ST_BODY;
                if ({5'b0, frame_count} == {1'b0, held_length} + {1'b0, MIN_LENGTH}) begin
                    if (rx == LF_BYTE) begin
                        r.byte_status     = ST_COMPLETE;
                        r.length_field    = held_length;
                        r.source_node     = held_source;
                        r.dest_node       = held_dest;
                        r.node_byte_count = held_node_count;
                        r.message_id      = held_msg_id;
                    end else begin
                        r.byte_status = ST_NO_LF;
                    end
                    clear_capture();
                end
            end
            default: begin
                // Anything but '@' is thrown away while waiting for a frame.
                if (rx == AT_SIGN) begin
                    clear_capture();
                    frame_phase      = PH_HEADER;
                    frame_count      = 12'd1;
                    r.frame_position = 12'd1;
                    r.byte_status    = ST_HEADER;
                end else begin
                    frame_phase = PH_IDLE;
                end
            end
        endcase
        parsed_due.insert(parsed_due.size(), r);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            failures++;
        end
    endfunction

    // Every result transfer is compared with the oldest outstanding prediction.
    always @(posedge aclk) begin : result_check
        sfd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (parsed_due.size() == 0) begin
                $display("%0t: unexpected result, expected nothing, got byte %h status %0d",
                         $time, m_tdata[7:0], m_tuser);
                failures++;
            end else begin
                want = parsed_due.pop_front();
                check_field("byte_out",        16'(want.byte_out),        16'(m_tdata[7:0]));
                check_field("byte_status",     16'(want.byte_status),     16'(m_tuser));
                check_field("frame_position",  16'(want.frame_position),  16'(m_tdata[19:8]));
                check_field("length_field",    want.length_field,         m_tdata[35:20]);
                check_field("source_node",     16'(want.source_node),     16'(m_tdata[43:36]));
                check_field("dest_node",       16'(want.dest_node),       16'(m_tdata[51:44]));
                check_field("node_byte_count", 16'(want.node_byte_count), 16'(m_tdata[59:52]));
                check_field("message_id",      16'(want.message_id),      16'(m_tdata[67:60]));
            end
        end
    end

    // The receiver stalls in short random bursts, and once for a long stretch
    // when a test asks for it. m_tready changes only at the falling edge.
    always @(negedge aclk) begin : receiver_stalls
        int hold_left;
        if (long_holds_served != long_holds_asked) begin
            long_holds_served = long_holds_asked;
            hold_left         = LONG_HOLD_CYCLES;
        end else if (hold_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 15);
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offers one byte, waits for its transfer, then predicts its result.
    // It is entered and left at a falling edge, so s_tvalid is never lowered
    // and raised within the same time step.
    task automatic send_byte(input logic [7:0] rx);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        predict_parse(rx);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Sends '@', four skipped header bytes and the length; stops there if the
    // length aborts the frame or if the stream was already inside a frame, so
    // that the bytes did not land on the length field. Otherwise it completes
    // the header and the body and closes with the given last byte.
    task automatic send_frame(input logic [15:0] len, input logic [7:0] last_byte);
        send_byte(AT_SIGN);
        repeat (4) send_byte(($urandom_range(0, 9) == 0) ? AT_SIGN : 8'($urandom));
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (frame_phase != PH_HEADER || frame_count != POS_LEN_HI || held_length != len) begin
            return;
        end
        repeat (4) send_byte(8'($urandom));
        repeat (int'(len) - 6) send_byte(8'($urandom));
        send_byte(last_byte);
    endtask

    // Brings the parser back to waiting for '@': zero length bytes end a header
    // as too short, and LF ends a body.
    task automatic close_open_frame();
        while (frame_phase != PH_IDLE) begin
            send_byte((frame_phase == PH_BODY) ? LF_BYTE : 8'h00);
        end
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (parsed_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Register writes happen only with no frame open and no result outstanding.
    task automatic write_limit(input logic [31:0] value);
        close_open_frame();
        wait_until_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        length_limit = value[11:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Noise, a minimal complete frame with '@' and extreme values in its header,
    // a too-short frame, and a frame one byte over the limit left from reset.
    task automatic test_directed_frames();
        logic [7:0] frame_bytes [0:27] = '{
            8'h00, 8'hFF,
            AT_SIGN, 8'hFF, 8'h00, AT_SIGN, 8'h0A, 8'h06, 8'h00,
            8'hFF, 8'h00, 8'h80, 8'h7F, LF_BYTE,
            AT_SIGN, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h00,
            AT_SIGN, 8'h11, 8'h22, 8'h33, 8'h44, 8'hE9, 8'h03
        };
        foreach (frame_bytes[i]) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // Lengths on either side of the limit at its extremes, including limits
    // below the minimum length and one above the cap, where a length just past
    // the cap must still count as too long.
    task automatic test_limit_extremes();
        write_limit(32'd6);
        send_frame(16'd6, LF_BYTE);
        send_frame(16'd7, LF_BYTE);
        write_limit(32'd5);
        send_frame(16'd5, LF_BYTE);
        send_frame(16'd6, LF_BYTE);
        write_limit(32'd0);
        send_frame(16'd0, LF_BYTE);
        send_frame(16'd1, LF_BYTE);
        write_limit(32'hFFFF_FFFF);
        send_frame(16'd4090, LF_BYTE);
        write_limit(32'd1000);
    endtask

    // The receiver stops for a long stretch while frames keep coming, so the
    // output stage fills and the input must stall.
    task automatic test_output_back_pressure();
        long_holds_asked++;
        repeat (3) send_frame(16'd20, LF_BYTE);
        close_open_frame();
        wait_until_drained();
    endtask

    // Mostly well-formed frames with random content and lengths, mixed with
    // noise, truncated frames, bad lengths and missing LFs.
    task automatic run_random_frames(input int bytes_wanted);
        int          stop_at;
        int          pick;
        logic [11:0] eff_limit;
        logic [11:0] short_top;
        logic [15:0] len;
        logic [7:0]  last_byte;
        stop_at   = bytes_sent + bytes_wanted;
        eff_limit = (length_limit > LENGTH_CAP) ? LENGTH_CAP : length_limit;
        short_top = (eff_limit < 12'd40) ? eff_limit : 12'd40;
        while (bytes_sent < stop_at) begin
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_byte(AT_SIGN);
                repeat ($urandom_range(1, 14)) send_byte(8'($urandom));
            end else begin
                if (pick < 70) begin
                    len = 16'($urandom_range(6, short_top));
                end else if (pick < 78) begin
                    len = (eff_limit <= 12'd64) ? {4'h0, eff_limit} : {4'h0, short_top};
                end else if (pick < 83) begin
                    len = {4'h0, eff_limit} + 16'd1;
                end else if (pick < 88) begin
                    // Any length over the limit, up to the largest the field holds.
                    len = 16'($urandom_range(int'(eff_limit) + 1, 65535));
                end else begin
                    len = 16'($urandom_range(0, 5));
                end
                last_byte = ($urandom_range(0, 6) == 0) ? 8'($urandom) : LF_BYTE;
                send_frame(len, last_byte);
            end
        end
        close_open_frame();
    endtask

    task automatic test_random_traffic();
        write_limit({20'($urandom), 12'($urandom_range(6, 64))});
        run_random_frames(300);
        write_limit({20'($urandom), 12'($urandom_range(6, 4095))});
        run_random_frames(200);
        write_limit({20'($urandom), 12'($urandom_range(6, 64))});
        run_random_frames(250);
    endtask

    // The closing stretch runs with both sides streaming at full rate.
    task automatic test_quiet_tail();
        idling_on = 1'b0;
        write_limit(32'd40);
        run_random_frames(250);
    endtask

    initial begin : run_tests
        int guard;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_limit_extremes();
        test_output_back_pressure();
        test_random_traffic();
        test_quiet_tail();

        // Let the last results come out, then keep the clock running to catch any
        // stray transfer.
        s_tvalid <= 1'b0;
        guard = 0;
        while (parsed_due.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (parsed_due.size() != 0) begin
            $display("%0t: %0d results never arrived, expected byte %h first, got none",
                     $time, parsed_due.size(), parsed_due[0].byte_out);
            failures++;
        end

        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
